@@ src/byte_ring_buffer_with_event_coalesce_defines.svh @@
// assertion macros used by the ring buffer top level
`ifndef BYTE_RING_BUFFER_WITH_EVENT_COALESCE_DEFINES_SVH
`define BYTE_RING_BUFFER_WITH_EVENT_COALESCE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BRB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BRB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/brb_pkg.sv @@
package brb_pkg;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned PW         = AW + 1;
  localparam int unsigned MAX_BYTES  = 8;
  localparam int unsigned CW         = 4;
  localparam int unsigned DW         = 64;
  localparam int unsigned IN_TDATA_W  = ((CW + DW + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((DW + PW + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_COAL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_SIZE   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOEVT = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0] evt_bytes;
    logic [2:0] key_start;
    logic [3:0] key_bytes;
  } cfg_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_t       status;
    logic [DW-1:0] read_data;
    logic [PW-1:0] fill_level;
  } res_t;

  function automatic logic [7:0] pay_byte(input logic [DW-1:0] v, input logic [2:0] k);
    pay_byte = v[8*k +: 8];
  endfunction

endpackage

@@ src/brb_store.sv @@
module brb_store (
  input  logic               clk,
  input  brb_pkg::mem_req_t  req,
  output logic [7:0]         rdata_r
);
  import brb_pkg::*;

  logic [7:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rdata_r <= mem_r[req.raddr];
  end

endmodule

@@ src/brb_ctrl.sv @@
module brb_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_req,
  input  logic [brb_pkg::CW-1:0]  in_count,
  input  logic [brb_pkg::DW-1:0]  in_payload,
  input  brb_pkg::cfg_t           cfg,
  output brb_pkg::mem_req_t       mem_req,
  input  logic [7:0]              rdata,
  output logic                    res_vld,
  input  logic                    res_rdy,
  output brb_pkg::res_t           res
);
  import brb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PUSH, S_POP, S_POP_WAIT, S_SCAN, S_EVAL, S_WRITE, S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [DW-1:0] pay_r, pay_nxt;
  logic [DW-1:0] rd_r, rd_nxt;
  status_t       status_r, status_nxt;
  logic [CW-1:0] n_r, n_nxt, k_r, k_nxt;
  logic          cap_vld_r, cap_vld_nxt;
  logic [2:0]    cap_k_r, cap_k_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [PW-1:0] rem_r, rem_nxt;
  logic          match_r, match_nxt;

  logic [PW-1:0] fill_w;
  logic [PW:0]   push_sum;
  logic [CW-1:0] nsat;
  logic [4:0]    win_end;
  logic          geo_bad;
  logic          byte_ok;
  logic [PW-1:0] rem_m;

  assign fill_w   = wp_r - rp_r;
  assign nsat     = (in_count > CW'(MAX_BYTES)) ? CW'(MAX_BYTES) : in_count;
  assign push_sum = {1'b0, fill_w} + (PW+1)'(nsat);
  assign win_end  = {2'b00, cfg.key_start} + {1'b0, cfg.key_bytes};
  assign geo_bad  = (cfg.evt_bytes == '0) || (cfg.evt_bytes > CW'(MAX_BYTES)) ||
                    (cfg.key_bytes == '0) || (win_end > {1'b0, cfg.evt_bytes}) ||
                    (fill_w < PW'(cfg.evt_bytes));
  assign byte_ok  = (rdata == pay_byte(pay_r, cap_k_r));
  assign rem_m    = rem_r - PW'(cfg.evt_bytes);

  assign in_ready       = (state_r == S_IDLE);
  assign res_vld        = (state_r == S_DONE);
  assign res.status     = status_r;
  assign res.read_data  = rd_r;
  assign res.fill_level = fill_w;

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    pay_nxt     = pay_r;
    rd_nxt      = rd_r;
    status_nxt  = status_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    cap_vld_nxt = 1'b0;
    cap_k_nxt   = cap_k_r;
    base_nxt    = base_r;
    rem_nxt     = rem_r;
    match_nxt   = match_r;
    mem_req     = '0;

    // popped byte arrives in the cycle after its read
    if (cap_vld_r && (state_r == S_POP || state_r == S_POP_WAIT)) begin
      rd_nxt[8*cap_k_r +: 8] = rdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pay_nxt    = in_payload;
          rd_nxt     = '0;
          k_nxt      = '0;
          n_nxt      = nsat;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (in_req)
            REQ_PUSH: begin
              if (push_sum > (PW+1)'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else if (nsat != '0) begin
                state_nxt = S_PUSH;
              end
            end
            REQ_POP: begin
              if (fill_w < PW'(nsat)) begin
                status_nxt = ST_EMPTY;
              end else if (nsat != '0) begin
                state_nxt = S_POP;
              end
            end
            REQ_COAL: begin
              if (geo_bad) begin
                status_nxt = ST_NOEVT;
              end else begin
                base_nxt  = rp_r[AW-1:0];
                rem_nxt   = fill_w;
                match_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_PUSH: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wp_r[AW-1:0];
        mem_req.wdata = pay_byte(pay_r, k_r[2:0]);
        wp_nxt        = wp_r + 1'b1;
        k_nxt         = k_r + 1'b1;
        if (k_r == n_r - 1'b1) begin
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        mem_req.raddr = rp_r[AW-1:0];
        rp_nxt        = rp_r + 1'b1;
        cap_vld_nxt   = 1'b1;
        cap_k_nxt     = k_r[2:0];
        k_nxt         = k_r + 1'b1;
        if (k_r == n_r - 1'b1) begin
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        mem_req.raddr = base_r + AW'(cfg.key_start) + AW'(k_r);
        cap_vld_nxt   = 1'b1;
        cap_k_nxt     = 3'({1'b0, cfg.key_start} + k_r);
        k_nxt         = k_r + 1'b1;
        if (cap_vld_r && !byte_ok) begin
          match_nxt = 1'b0;
        end
        if (k_r == cfg.key_bytes - 1'b1) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        k_nxt = '0;
        if (match_r && byte_ok) begin
          state_nxt = S_WRITE;
        end else begin
          base_nxt = base_r + AW'(cfg.evt_bytes);
          rem_nxt  = rem_m;
          if (rem_m >= PW'(cfg.evt_bytes)) begin
            match_nxt = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            status_nxt = ST_NOEVT;
            state_nxt  = S_DONE;
          end
        end
      end
      S_WRITE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = base_r + AW'(k_r);
        mem_req.wdata = pay_byte(pay_r, k_r[2:0]);
        k_nxt         = k_r + 1'b1;
        if (k_r == cfg.evt_bytes - 1'b1) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_rdy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wp_r      <= '0;
      rp_r      <= '0;
      cap_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      cap_vld_r <= cap_vld_nxt;
    end
    pay_r    <= pay_nxt;
    rd_r     <= rd_nxt;
    status_r <= status_nxt;
    n_r      <= n_nxt;
    k_r      <= k_nxt;
    cap_k_r  <= cap_k_nxt;
    base_r   <= base_nxt;
    rem_r    <= rem_nxt;
    match_r  <= match_nxt;
  end

endmodule

@@ src/byte_ring_buffer_with_event_coalesce.sv @@
// byte ring fifo of 1024 bytes with in-place event coalescing
// in channel: in_tuser carries the request kind (push, pop, coalesce), in_tdata the
//   byte count and the payload; one request is worked on at a time
// out channel: one result per request, in_tuser-style status on out_tuser, popped
//   bytes and fill level on out_tdata
// cfg channel: always ready; write event length, key offset, key length only while idle
// the byte store is a single-port-write, single-port-read memory moving one byte a
//   cycle, so a request's length is set by its byte count
//   push of n bytes: n + 2 cycles from accept to out_tvalid
//   pop of n bytes:  n + 3 cycles
//   failed, empty or zero-count request: 2 cycles
//   coalesce: 2 + e * (key length + 1) + event length cycles when event e (from 1) hits,
//     up to 2 + events_held * (key length + 1) when none does
// the result sits in an output register; a new request is taken while it waits,
//   and a stalled out_tready holds the next result inside until the register frees
// reset empties the ring (both pointers zero) and loads event length 1, key offset 0,
//   key length 1; store contents are not cleared
`include "byte_ring_buffer_with_event_coalesce_defines.svh"

module byte_ring_buffer_with_event_coalesce (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [brb_pkg::IN_TDATA_W-1:0]      in_tdata,   // byte_count, payload
  input  logic [1:0]                          in_tuser,   // req_type
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [brb_pkg::OUT_TDATA_W-1:0]     out_tdata,  // read_data, fill_level
  output logic [1:0]                          out_tuser,  // status
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [brb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [brb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import brb_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  mem_req_t mem_req;
  logic [7:0] rdata;
  logic     res_vld, res_rdy;
  res_t     res;
  logic     out_valid_r, out_valid_nxt;
  res_t     out_res_r, out_res_nxt;

  brb_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rdata_r (rdata)
  );

  brb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_req     (in_tuser),
    .in_count   (in_tdata[CW-1:0]),
    .in_payload (in_tdata[CW +: DW]),
    .cfg        (cfg_r),
    .mem_req    (mem_req),
    .rdata      (rdata),
    .res_vld    (res_vld),
    .res_rdy    (res_rdy),
    .res        (res)
  );

  assign cfg_ready  = 1'b1;
  assign res_rdy    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {{(OUT_TDATA_W - DW - PW){1'b0}}, out_res_r.fill_level,
                       out_res_r.read_data};

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EVENT_SIZE:   cfg_nxt.evt_bytes = cfg_data[3:0];
        CFG_MATCH_OFFSET: cfg_nxt.key_start = cfg_data[2:0];
        CFG_MATCH_SIZE:   cfg_nxt.key_bytes = cfg_data[3:0];
        default: ;
      endcase
    end
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_rdy) begin
      out_valid_nxt = res_vld;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.evt_bytes <= 4'd1;
      cfg_r.key_start <= 3'd0;
      cfg_r.key_bytes <= 4'd1;
      out_valid_r     <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  `BRB_ASSERT_IMP(a_fill_bound, out_valid_r, out_res_r.fill_level <= PW'(DEPTH), "fill above depth")
  `BRB_ASSERT_IMP(a_fail_no_data, out_valid_r && out_res_r.status != ST_OK, out_res_r.read_data == '0, "data on failed request")
  `BRB_ASSERT_NXT(a_one_request, in_tvalid && in_tready, !in_tready, "second request taken while busy")

endmodule

@@ sim/byte_ring_buffer_with_event_coalesce_test.sv @@
`timescale 1ns / 100ps

module byte_ring_buffer_with_event_coalesce_test;
  import brb_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 25_000_000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;   // byte_count, payload
  logic [1:0] in_tuser;              // req_type
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata; // read_data, fill_level
  logic [1:0] out_tuser;             // status
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  byte_ring_buffer_with_event_coalesce u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ring image and event format as the block should hold them
  logic [7:0] ring_mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [3:0] ev_size;
  logic [2:0] key_off;
  logic [3:0] key_len;

  res_t pending_results[$];
  res_t head;
  int mismatches = 0;
  int unsigned cycle_count = 0;
  int stall_left = 0;
  bit steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0 && !steady && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
    end
    out_tready = (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  function automatic int held_bytes();
    logic [PW-1:0] diff;
    diff = wr_ptr - rd_ptr;
    return int'(diff);
  endfunction

  function automatic status_t coalesce_into_ring(input logic [63:0] pay);
    int held;
    int events;
    int base;
    bit hit;
    held = held_bytes();
    if (ev_size == 0 || ev_size > MAX_BYTES || key_len == 0 ||
        int'(key_off) + int'(key_len) > int'(ev_size) || held < int'(ev_size)) begin
      return ST_NOEVT;
    end
    events = held / int'(ev_size);
    for (int idx = 0; idx < events; idx++) begin
      base = int'(rd_ptr) + idx * int'(ev_size);
      hit = 1'b1;
      for (int k = int'(key_off); k < int'(key_off) + int'(key_len); k++) begin
        if (ring_mem[(base + k) & (DEPTH - 1)] != pay[8*k +: 8]) begin
          hit = 1'b0;
          break;
        end
      end
      if (hit) begin
        for (int k = 0; k < int'(ev_size); k++) ring_mem[(base + k) & (DEPTH - 1)] = pay[8*k +: 8];
        return ST_OK;
      end
    end
    return ST_NOEVT;
  endfunction

  function automatic res_t ring_access(input logic [1:0] kind, input logic [3:0] cnt,
                                       input logic [63:0] pay);
    int n;
    int held;
    res_t r;
    r.status = ST_OK;
    r.read_data = '0;
    n = (cnt > MAX_BYTES) ? MAX_BYTES : int'(cnt);
    held = held_bytes();
    case (kind)
      REQ_PUSH: begin
        if (held + n > DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int k = 0; k < n; k++) begin
            ring_mem[wr_ptr[AW-1:0]] = pay[8*k +: 8];
            wr_ptr = wr_ptr + 1'b1;
          end
        end
      end
      REQ_POP: begin
        if (held < n) begin
          r.status = ST_EMPTY;
        end else begin
          for (int k = 0; k < n; k++) begin
            r.read_data[8*k +: 8] = ring_mem[rd_ptr[AW-1:0]];
            rd_ptr = rd_ptr + 1'b1;
          end
        end
      end
      REQ_COAL: r.status = coalesce_into_ring(pay);
      default: ;
    endcase
    r.fill_level = wr_ptr - rd_ptr;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // key bytes from a tiny pool so that several stored events share a key
  function automatic logic [63:0] event_payload();
    logic [63:0] r;
    r = rand64();
    for (int k = int'(key_off); k < int'(key_off) + int'(key_len); k++) begin
      r[8*k +: 8] = 8'($urandom_range(0, 3) * 85);
    end
    return r;
  endfunction

  function automatic logic [63:0] with_stored_key(input int idx, input logic [63:0] pay);
    int base;
    logic [63:0] r;
    r = pay;
    base = int'(rd_ptr) + idx * int'(ev_size);
    for (int k = int'(key_off); k < int'(key_off) + int'(key_len); k++) begin
      r[8*k +: 8] = ring_mem[(base + k) & (DEPTH - 1)];
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic log_mismatch(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        log_mismatch("result with no request", '0, out_tdata[DW-1:0]);
      end else begin
        head = pending_results.pop_front();
        if (out_tuser !== head.status) log_mismatch("status", head.status, out_tuser);
        if (out_tdata[DW-1:0] !== head.read_data) begin
          log_mismatch("read_data", head.read_data, out_tdata[DW-1:0]);
        end
        if (out_tdata[DW +: PW] !== head.fill_level) begin
          log_mismatch("fill_level", head.fill_level, out_tdata[DW +: PW]);
        end
      end
    end
  end

  // called at a falling edge; leaves in_tvalid high when no gap follows
  task automatic send_request(input logic [1:0] kind, input logic [3:0] cnt,
                              input logic [63:0] pay);
    int gap;
    in_tuser = kind;
    in_tdata = {4'b0, pay, cnt};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(ring_access(kind, cnt, pay));
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_until_idle();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_event_format(input logic [3:0] es, input logic [3:0] off_raw,
                                  input logic [3:0] ks);
    logic [CFG_IDX_W-1:0] regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    regs[0] = CFG_EVENT_SIZE;
    regs[1] = CFG_MATCH_OFFSET;
    regs[2] = CFG_MATCH_SIZE;
    vals[0] = es;
    vals[1] = off_raw;
    vals[2] = ks;
    wait_until_idle();
    cfg_valid = 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index = regs[i];
      cfg_data = vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (regs[i])
        CFG_EVENT_SIZE: ev_size = vals[i];
        CFG_MATCH_OFFSET: key_off = vals[i][2:0];
        CFG_MATCH_SIZE: key_len = vals[i];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  task automatic test_basic_requests();
    send_request(REQ_POP, 4'd1, '0);
    send_request(REQ_POP, 4'd0, '1);
    send_request(REQ_COAL, 4'd0, '0);
    send_request(REQ_PUSH, 4'd0, '1);
    send_request(REQ_PUSH, 4'd8, '1);
    send_request(REQ_PUSH, 4'd15, '0);
    send_request(REQ_PUSH, 4'd3, 64'h0123_4567_89AB_CDEF);
    send_request(REQ_UNUSED, 4'd15, '1);
    send_request(REQ_COAL, 4'd15, 64'h0000_0000_0000_00EF);
    send_request(REQ_COAL, 4'd0, 64'hFFFF_FFFF_FFFF_FF5A);
    send_request(REQ_POP, 4'd15, '0);
    send_request(REQ_POP, 4'd5, '0);
    send_request(REQ_POP, 4'd8, '0);
    send_request(REQ_POP, 4'd6, '0);
  endtask

  task automatic test_event_geometry();
    set_event_format(4'd4, 4'd1, 4'd2);
    send_request(REQ_PUSH, 4'd8, 64'h4433_2211_0403_0201);
    send_request(REQ_PUSH, 4'd3, 64'h0000_0000_000A_0B0C);
    send_request(REQ_COAL, 4'd0, 64'hFFFF_FFFF_DD33_22CC);
    // key only present in the partial trailing event
    send_request(REQ_COAL, 4'd0, 64'h0000_0000_000A_0B00);
    set_event_format(4'd0, 4'd0, 4'd1);
    send_request(REQ_COAL, 4'd0, 64'hDD33_2277_6655_4433);
    set_event_format(4'd9, 4'd0, 4'd1);
    send_request(REQ_COAL, 4'd0, 64'hDD33_2277_6655_4433);
    set_event_format(4'd15, 4'd0, 4'd1);
    send_request(REQ_COAL, 4'd0, 64'hDD33_2277_6655_4433);
    set_event_format(4'd8, 4'd0, 4'd0);
    send_request(REQ_COAL, 4'd0, 64'hDD33_2277_6655_4433);
    set_event_format(4'd8, 4'd0, 4'd9);
    send_request(REQ_COAL, 4'd0, 64'hDD33_2277_6655_4433);
    set_event_format(4'd8, 4'd7, 4'd2);
    send_request(REQ_COAL, 4'd0, 64'hDD33_2277_6655_4433);
    set_event_format(4'd8, 4'hD, 4'd3);
    send_request(REQ_COAL, 4'd0, 64'hDD33_2277_6655_4433);
    set_event_format(4'd8, 4'd0, 4'd8);
    send_request(REQ_COAL, 4'd0, 64'hDD33_2277_6655_4433);
    send_request(REQ_COAL, 4'd0, 64'hDD33_2277_6655_4434);
    send_request(REQ_POP, 4'd8, '0);
    send_request(REQ_POP, 4'd3, '0);
  endtask

  task automatic test_ring_full_and_wrap();
    int n;
    set_event_format(4'd8, 4'd2, 4'd4);
    while (held_bytes() > 0) begin
      n = (held_bytes() < 8) ? held_bytes() : 8;
      send_request(REQ_POP, 4'(n), rand64());
    end
    while (held_bytes() < 1020) begin
      n = $urandom_range(1, 8);
      if (held_bytes() + n > 1020) n = 1020 - held_bytes();
      send_request(REQ_PUSH, 4'(n), rand64());
    end
    send_request(REQ_PUSH, 4'd8, rand64());
    send_request(REQ_PUSH, 4'd4, rand64());
    send_request(REQ_PUSH, 4'd1, rand64());
    send_request(REQ_PUSH, 4'd0, rand64());
    send_request(REQ_COAL, 4'd0, with_stored_key(127, rand64()));
    send_request(REQ_COAL, 4'd0, rand64());
    while (held_bytes() >= 8) send_request(REQ_POP, 4'($urandom_range(1, 15)), rand64());
    send_request(REQ_POP, 4'd8, rand64());
    send_request(REQ_POP, 4'(held_bytes()), rand64());
  endtask

  task automatic random_event_step();
    int held;
    int events;
    int pick;
    logic [63:0] pay;
    held = held_bytes();
    events = held / int'(ev_size);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), rand64());
    end else if ((held > 160 && pick < 85) || (held >= int'(ev_size) && pick >= 75)) begin
      send_request(REQ_POP, ev_size, rand64());
    end else if (events > 0 && pick >= 50) begin
      pay = event_payload();
      if ($urandom_range(0, 2) != 0) pay = with_stored_key($urandom_range(0, events - 1), pay);
      send_request(REQ_COAL, 4'($urandom_range(0, 15)), pay);
    end else begin
      send_request(REQ_PUSH, ev_size, event_payload());
    end
  endtask

  task automatic test_random_event_traffic();
    logic [3:0] es;
    logic [3:0] ko;
    logic [3:0] ks;
    for (int setting = 0; setting < 6; setting++) begin
      case (setting)
        0: begin
          es = 4'd1; ko = 4'd0; ks = 4'd1;
        end
        1: begin
          es = 4'd8; ko = 4'd0; ks = 4'd8;
        end
        2: begin
          es = 4'd8; ko = 4'd7; ks = 4'd1;
        end
        3: begin
          es = 4'd5; ko = 4'd2; ks = 4'd3;
        end
        4: begin
          es = 4'd3; ko = 4'd1; ks = 4'd2;
        end
        default: begin
          es = 4'($urandom_range(1, 8));
          ks = 4'($urandom_range(1, es));
          ko = 4'($urandom_range(0, es - ks));
        end
      endcase
      set_event_format(es, ko, ks);
      for (int i = 0; i < 250; i++) begin
        if (i % 80 == 0) steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 149) == 0) wait_until_idle();
        random_event_step();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    wr_ptr = '0;
    rd_ptr = '0;
    ev_size = 4'd1;
    key_off = 3'd0;
    key_len = 4'd1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_requests();
    test_event_geometry();
    test_ring_full_and_wrap();
    test_random_event_traffic();

    wait_until_idle();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
